// ===== rtl/amqp_type_header_decoder_core_assert.svh =====
// Assertion macros shared by the checker of the value header decoder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef AMQP_TYPE_HEADER_DECODER_CORE_ASSERT_SVH
`define AMQP_TYPE_HEADER_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define AHD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define AHD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ahd_pkg.sv =====
// Types, codes and format-code helpers for the value header decoder.
// No dependencies; every module of the block imports this package.
`default_nettype none

package ahd_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } ahd_in_t;

  typedef struct packed {
    logic [7:0]  format_code;
    logic [31:0] body_length;
    logic [31:0] element_count;
    logic [2:0]  count_bytes;
    logic [2:0]  error_code;
  } ahd_out_t;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_NO_TAG    = 3'd1;
  localparam logic [2:0] ERR_BAD_TAG   = 3'd2;
  localparam logic [2:0] ERR_SHORT_LEN = 3'd3;
  localparam logic [2:0] ERR_SHORT_CNT = 3'd4;
  localparam logic [2:0] ERR_ODD_MAP   = 3'd5;
  localparam logic [2:0] ERR_CNT_WIDE  = 3'd6;

  // Upper nibbles of the format code.
  localparam logic [3:0] NIB_4 = 4'h4;
  localparam logic [3:0] NIB_5 = 4'h5;
  localparam logic [3:0] NIB_6 = 4'h6;
  localparam logic [3:0] NIB_7 = 4'h7;
  localparam logic [3:0] NIB_8 = 4'h8;
  localparam logic [3:0] NIB_9 = 4'h9;
  localparam logic [3:0] NIB_A = 4'hA;
  localparam logic [3:0] NIB_B = 4'hB;
  localparam logic [3:0] NIB_C = 4'hC;
  localparam logic [3:0] NIB_D = 4'hD;
  localparam logic [3:0] NIB_E = 4'hE;
  localparam logic [3:0] NIB_F = 4'hF;

  localparam logic [7:0] TAG_MAP8  = 8'hC1;
  localparam logic [7:0] TAG_MAP32 = 8'hD1;

  // Width of the size field in bytes.
  function automatic logic [2:0] size_width(input logic [7:0] tag);
    case (tag[7:4])
      NIB_B, NIB_D, NIB_F: size_width = 3'd4;
      NIB_A, NIB_C, NIB_E: size_width = 3'd1;
      default:             size_width = 3'd0;
    endcase
  endfunction

  // Width of the element count field in bytes.
  function automatic logic [2:0] count_width(input logic [7:0] tag);
    case (tag[7:4])
      NIB_D, NIB_F: count_width = 3'd4;
      NIB_C, NIB_E: count_width = 3'd1;
      default:      count_width = 3'd0;
    endcase
  endfunction

  // Body length of a fixed-width code.
  function automatic logic [4:0] fixed_length(input logic [7:0] tag);
    case (tag[7:4])
      NIB_5:   fixed_length = 5'd1;
      NIB_6:   fixed_length = 5'd2;
      NIB_7:   fixed_length = 5'd4;
      NIB_8:   fixed_length = 5'd8;
      NIB_9:   fixed_length = 5'd16;
      default: fixed_length = 5'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/amqp_type_header_decoder_core.sv =====
// Top level of the AMQP 1.0 value header decoder.
// Instantiates ahd_in_stage, ahd_decode and ahd_out_stage; uses ahd_pkg.
//
// The input channel (in_valid, in_stall, in_data) takes one request per
// cycle while in_stall is low: a stream byte, or an end-of-data mark when
// in_data.kind is set. For each top-level value the block reports the format
// code, body length, element count and count width, or an error code, on
// the result channel (out_valid, out_stall, out_data). The request that
// completes the header is held in the input register, then parsed, and its
// result is loaded into the result register, where out_valid rises. The
// block takes one byte per cycle while the receiver does not stall. Bytes
// that complete no header give no result.
// When the receiver stalls, the held result stays on out_data, the input
// register keeps one request and in_stall rises once it is full. After reset
// both registers are empty and the decoder waits for a format code.
`default_nettype none

module amqp_type_header_decoder_core (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  ahd_pkg::ahd_in_t   in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output ahd_pkg::ahd_out_t  out_data
);
  import ahd_pkg::*;

  logic     adv;
  logic     step;
  ahd_in_t  item;
  logic     res_valid;
  ahd_out_t res;

  ahd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .step     (step),
    .item     (item)
  );

  ahd_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ahd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/ahd_in_stage.sv =====
// Input register of the value header decoder: holds one accepted request.
// Depends on ahd_pkg for the request type.
`default_nettype none

module ahd_in_stage (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  ahd_pkg::ahd_in_t in_data,
  input  wire             adv,
  output logic            step,
  output ahd_pkg::ahd_in_t item
);
  import ahd_pkg::*;

  logic    valid_r, valid_nxt;
  ahd_in_t data_r;
  logic    load;

  assign in_stall = valid_r && !adv;
  assign load     = in_valid && !in_stall;
  assign step     = valid_r && adv;
  assign item     = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ahd_decode.sv =====
// Header parse state and the single-pass next-state and result logic.
// Depends on ahd_pkg for types, error codes and format-code helpers.
`default_nettype none

module ahd_decode (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              step,
  input  ahd_pkg::ahd_in_t  item,
  output logic             res_valid,
  output ahd_pkg::ahd_out_t res
);
  import ahd_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_LEN,
    PH_CNT,
    PH_SKIP,
    PH_DISC
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] skip_r, skip_nxt;

  logic [7:0]  b;
  logic        is_end;
  logic [1:0]  idx_inc;
  logic [31:0] len_shift;
  logic [31:0] cnt_shift;
  logic [2:0]  sw;
  logic [2:0]  cw;
  logic [4:0]  fl;
  logic [31:0] rem;

  assign b         = item.data_byte;
  assign is_end    = item.kind;
  assign idx_inc   = idx_r + 2'd1;
  assign len_shift = {len_r[23:0], b};
  assign cnt_shift = {cnt_r[23:0], b};
  assign sw        = size_width(tag_r);
  assign cw        = count_width(tag_r);
  assign fl        = fixed_length(b);
  assign rem       = len_r - {29'd0, cw};

  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    skip_nxt  = skip_r;
    res_valid = 1'b0;
    res       = '0;
    if (step) begin
      case (phase_r)
        PH_TAG: begin
          if (is_end) begin
            res_valid      = 1'b1;
            res.error_code = ERR_NO_TAG;
          end else begin
            tag_nxt = b;
            len_nxt = '0;
            cnt_nxt = '0;
            idx_nxt = '0;
            if (b[7:4] < NIB_4) begin
              res_valid       = 1'b1;
              res.format_code = b;
              res.error_code  = ERR_BAD_TAG;
              phase_nxt       = PH_DISC;
            end else if (b[7:4] <= NIB_9) begin
              // Fixed-width code: the result goes out on the tag byte.
              len_nxt         = {27'd0, fl};
              skip_nxt        = {27'd0, fl};
              res_valid       = 1'b1;
              res.format_code = b;
              res.body_length = {27'd0, fl};
              res.error_code  = ERR_OK;
              phase_nxt       = (fl == 5'd0) ? PH_TAG : PH_SKIP;
            end else begin
              phase_nxt = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          if (is_end) begin
            res_valid       = 1'b1;
            res.format_code = tag_r;
            res.error_code  = ERR_SHORT_LEN;
            phase_nxt       = PH_TAG;
          end else begin
            len_nxt = len_shift;
            idx_nxt = idx_inc;
            // A four-byte field wraps the index back to zero on its last byte.
            if (idx_inc == sw[1:0]) begin
              idx_nxt = '0;
              if (cw == 3'd0) begin
                res_valid       = 1'b1;
                res.format_code = tag_r;
                res.body_length = len_shift;
                res.error_code  = ERR_OK;
                skip_nxt        = len_shift;
                phase_nxt       = (len_shift == '0) ? PH_TAG : PH_SKIP;
              end else begin
                phase_nxt = PH_CNT;
              end
            end
          end
        end
        PH_CNT: begin
          if (is_end) begin
            res_valid       = 1'b1;
            res.format_code = tag_r;
            res.body_length = len_r;
            res.error_code  = ERR_SHORT_CNT;
            phase_nxt       = PH_TAG;
          end else begin
            cnt_nxt = cnt_shift;
            idx_nxt = idx_inc;
            if (idx_inc == cw[1:0]) begin
              idx_nxt           = '0;
              res_valid         = 1'b1;
              res.format_code   = tag_r;
              res.body_length   = len_r;
              res.element_count = cnt_shift;
              res.count_bytes   = cw;
              if ((tag_r == TAG_MAP8 || tag_r == TAG_MAP32) && cnt_shift[0]) begin
                res.error_code = ERR_ODD_MAP;
                phase_nxt      = PH_DISC;
              end else if ({29'd0, cw} > len_r) begin
                res.error_code = ERR_CNT_WIDE;
                phase_nxt      = PH_DISC;
              end else begin
                res.error_code = ERR_OK;
                skip_nxt       = rem;
                phase_nxt      = (rem == '0) ? PH_TAG : PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (is_end || skip_r <= 32'd1) begin
            skip_nxt  = '0;
            phase_nxt = PH_TAG;
          end else begin
            skip_nxt = skip_r - 32'd1;
          end
        end
        PH_DISC: begin
          if (is_end) begin
            phase_nxt = PH_TAG;
          end
        end
        default: begin
          phase_nxt = PH_TAG;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      tag_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      skip_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ahd_out_stage.sv =====
// Result register of the value header decoder with its valid/stall handshake.
// Depends on ahd_pkg for the result type.
`default_nettype none

module ahd_out_stage (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               step,
  input  wire               res_valid,
  input  ahd_pkg::ahd_out_t  res,
  output logic              adv,
  output logic              out_valid,
  input  wire               out_stall,
  output ahd_pkg::ahd_out_t  out_data
);
  import ahd_pkg::*;

  logic     valid_r, valid_nxt;
  ahd_out_t data_r;
  logic     load;

  // The decoder may step whenever the register is empty or being emptied.
  assign adv       = !valid_r || !out_stall;
  assign load      = step && res_valid;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ahd_checker.sv =====
// Port-level checks for the value header decoder, bound to its top level.
// Depends on ahd_pkg and the assertion macros in the shared header.
`default_nettype none

`include "amqp_type_header_decoder_core_assert.svh"

module ahd_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input ahd_pkg::ahd_out_t  out_data
);
  import ahd_pkg::*;

  logic held;
  logic no_tag_res;
  logic ok_res;
  logic cb_legal;
  logic no_tag_clean;
  logic cnt_fits;

  assign held         = out_valid && out_stall;
  assign no_tag_res   = out_valid && out_data.error_code == ERR_NO_TAG;
  assign ok_res       = out_valid && out_data.error_code == ERR_OK;
  assign cb_legal     = out_data.count_bytes == 3'd0 || out_data.count_bytes == 3'd1 ||
                        out_data.count_bytes == 3'd4;
  assign no_tag_clean = out_data.format_code == 8'd0 && out_data.body_length == 32'd0;
  assign cnt_fits     = out_data.body_length >= {29'd0, out_data.count_bytes};

  `AHD_ASSERT_NXT(a_out_hold, held, out_valid && $stable(out_data), "stalled result changed")
  `AHD_ASSERT_IMP(a_cb_legal, out_valid, cb_legal, "illegal count width")
  `AHD_ASSERT_IMP(a_no_tag, no_tag_res, no_tag_clean, "no-tag result has fields")
  `AHD_ASSERT_IMP(a_cnt_fits, ok_res, cnt_fits, "count wider than body")
  // With the result register empty the input side can always take a request.
  `AHD_ASSERT_IMP(a_in_ready, !out_valid, !in_stall, "input stalled with empty output")

endmodule

bind amqp_type_header_decoder_core ahd_checker u_ahd_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for amqp_type_header_decoder_core: a directed table of
// requests, then random AMQP 1.0 value streams, each header report checked in order.
// Depends on ahd_pkg and the RTL of the decoder only.

module tb_top;
  import ahd_pkg::*;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam int unsigned RANDOM_REQS  = 1625;
  localparam int unsigned CALM_FROM    = 1450;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    AWAIT_CODE, READ_SIZE, READ_COUNT, SKIP_BODY, DROP_TO_END
  } hdr_step_t;

  typedef struct packed {
    ahd_in_t  req;
    logic     given;
    ahd_out_t res;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ahd_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  ahd_out_t out_data;

  // Typed-in expectation that travels with the request on the input channel.
  logic     row_given;
  ahd_out_t row_res;

  dir_row_t dir_rows[$];
  ahd_in_t  plan_q[$];
  ahd_out_t header_q[$];

  // Decoder model state.
  hdr_step_t   p_step = AWAIT_CODE;
  logic [7:0]  p_code = '0;
  logic [31:0] p_size = '0;
  logic [31:0] p_count = '0;
  logic [31:0] p_left = '0;
  logic [1:0]  p_pos = '0;

  bit          pred_emits;
  ahd_out_t    pred_hdr;
  ahd_out_t    want_hdr;

  int unsigned fail_count = 0;
  int unsigned reqs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned err_seen[8];
  int unsigned in_idle_pct = 15;
  int unsigned out_idle_pct = 15;
  int unsigned stall_left = 0;
  bit          calm_tail = 1'b0;

  amqp_type_header_decoder_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [2:0] size_field_bytes(input logic [7:0] code);
    if (code[7:4] < NIB_A) return 3'd0;
    return code[4] ? 3'd4 : 3'd1;
  endfunction

  function automatic logic [2:0] count_field_bytes(input logic [7:0] code);
    if (code[7:4] < NIB_C) return 3'd0;
    return code[4] ? 3'd4 : 3'd1;
  endfunction

  // Fixed widths double from one byte at nibble 5 up to sixteen at nibble 9.
  function automatic logic [31:0] fixed_body(input logic [7:0] code);
    if (code[7:4] == NIB_4) return 32'd0;
    return 32'd1 << (code[7:4] - NIB_5);
  endfunction

  task automatic begin_skip(input logic [31:0] n);
    p_left = n;
    if (n == 32'd0) p_step = AWAIT_CODE;
    else p_step = SKIP_BODY;
  endtask

  task automatic decode_byte(input ahd_in_t req, output bit emits, output ahd_out_t res);
    logic [7:0] b;
    logic [2:0] sw;
    logic [2:0] cw;
    b = req.data_byte;
    sw = size_field_bytes(p_code);
    cw = count_field_bytes(p_code);
    emits = 1'b0;
    res = '0;
    res.format_code = p_code;
    case (p_step)
      AWAIT_CODE: begin
        if (req.kind == KIND_END) begin
          emits = 1'b1;
          res.format_code = 8'h00;
          res.error_code = ERR_NO_TAG;
        end else begin
          p_code = b;
          p_size = '0;
          p_count = '0;
          p_pos = '0;
          res.format_code = b;
          if (b[7:4] < NIB_4) begin
            emits = 1'b1;
            res.error_code = ERR_BAD_TAG;
            p_step = DROP_TO_END;
          end else if (b[7:4] < NIB_A) begin
            p_size = fixed_body(b);
            emits = 1'b1;
            res.body_length = p_size;
            res.error_code = ERR_OK;
            begin_skip(p_size);
          end else begin
            p_step = READ_SIZE;
          end
        end
      end
      READ_SIZE: begin
        if (req.kind == KIND_END) begin
          emits = 1'b1;
          res.error_code = ERR_SHORT_LEN;
          p_step = AWAIT_CODE;
        end else begin
          p_size = {p_size[23:0], b};
          p_pos = p_pos + 2'd1;
          // A four-byte field wraps the index back to zero.
          if (p_pos == sw[1:0]) begin
            p_pos = '0;
            if (cw == 3'd0) begin
              emits = 1'b1;
              res.body_length = p_size;
              res.error_code = ERR_OK;
              begin_skip(p_size);
            end else begin
              p_step = READ_COUNT;
            end
          end
        end
      end
      READ_COUNT: begin
        if (req.kind == KIND_END) begin
          emits = 1'b1;
          res.body_length = p_size;
          res.error_code = ERR_SHORT_CNT;
          p_step = AWAIT_CODE;
        end else begin
          p_count = {p_count[23:0], b};
          p_pos = p_pos + 2'd1;
          if (p_pos == cw[1:0]) begin
            p_pos = '0;
            emits = 1'b1;
            res.body_length = p_size;
            res.element_count = p_count;
            res.count_bytes = cw;
            if ((p_code == TAG_MAP8 || p_code == TAG_MAP32) && p_count[0]) begin
              res.error_code = ERR_ODD_MAP;
              p_step = DROP_TO_END;
            end else if ({29'd0, cw} > p_size) begin
              res.error_code = ERR_CNT_WIDE;
              p_step = DROP_TO_END;
            end else begin
              res.error_code = ERR_OK;
              begin_skip(p_size - {29'd0, cw});
            end
          end
        end
      end
      SKIP_BODY: begin
        if (req.kind == KIND_END || p_left <= 32'd1) begin
          p_left = '0;
          p_step = AWAIT_CODE;
        end else begin
          p_left = p_left - 32'd1;
        end
      end
      default: begin
        if (req.kind == KIND_END) p_step = AWAIT_CODE;
      end
    endcase
  endtask

  task automatic report_fail(input string what, input ahd_out_t want, input ahd_out_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected code %02h len %0d cnt %0d cb %0d err %0d",
               $time, what, want.format_code, want.body_length, want.element_count,
               want.count_bytes, want.error_code);
      $display("%0t %s: actual   code %02h len %0d cnt %0d cb %0d err %0d",
               $time, what, got.format_code, got.body_length, got.element_count,
               got.count_bytes, got.error_code);
    end
  endtask

  // Every accepted request goes through the model; reports are queued in order.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      decode_byte(in_data, pred_emits, pred_hdr);
      if (row_given) header_q.push_back(row_res);
      else if (pred_emits) header_q.push_back(pred_hdr);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      err_seen[out_data.error_code]++;
      if (header_q.size() == 0) begin
        report_fail("unexpected report", '0, out_data);
      end else begin
        want_hdr = header_q.pop_front();
        if (want_hdr.format_code !== out_data.format_code ||
            want_hdr.body_length !== out_data.body_length ||
            want_hdr.element_count !== out_data.element_count ||
            want_hdr.count_bytes !== out_data.count_bytes ||
            want_hdr.error_code !== out_data.error_code)
          report_fail("mismatch", want_hdr, out_data);
      end
    end
  end

  // Receiver back-pressure in bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (calm_tail) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        stall_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_row(input logic kind, input logic [7:0] data, input logic given,
                         input logic [7:0] fc, input logic [31:0] len,
                         input logic [31:0] cnt, input logic [2:0] cb,
                         input logic [2:0] err);
    dir_row_t row;
    row.req.kind = kind;
    row.req.data_byte = data;
    row.given = given;
    row.res.format_code = fc;
    row.res.body_length = len;
    row.res.element_count = cnt;
    row.res.count_bytes = cb;
    row.res.error_code = err;
    dir_rows.push_back(row);
  endtask

  task automatic send_req(input ahd_in_t req, input logic given, input ahd_out_t typed);
    if (!calm_tail && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    row_given <= given;
    row_res <= typed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    reqs_sent++;
  endtask

  task automatic plan_byte(input logic [7:0] b);
    ahd_in_t req;
    req.kind = KIND_BYTE;
    req.data_byte = b;
    plan_q.push_back(req);
  endtask

  task automatic plan_mark();
    ahd_in_t req;
    req.kind = KIND_END;
    req.data_byte = 8'($urandom_range(0, 255));
    plan_q.push_back(req);
  endtask

  task automatic plan_bytes(input int unsigned k);
    int unsigned i;
    for (i = 0; i < k; i++) plan_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic plan_field(input logic [31:0] value, input logic [2:0] nbytes);
    int i;
    for (i = nbytes - 1; i >= 0; i--) plan_byte(value[8*i +: 8]);
  endtask

  // Long bodies are cut short by an end mark to keep the run brief.
  task automatic plan_body(input logic [31:0] n);
    if (n <= 32'd24) begin
      plan_bytes(n);
    end else begin
      plan_bytes($urandom_range(0, 8));
      plan_mark();
    end
  endtask

  function automatic logic [31:0] pick_field_value(input logic [2:0] nbytes);
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, 12);
    if (nbytes == 3'd4) return $urandom;
    return $urandom_range(0, 255);
  endfunction

  task automatic plan_value();
    int unsigned pick;
    logic [7:0]  code;
    logic [2:0]  sw;
    logic [2:0]  cw;
    logic [31:0] body_len;
    logic [31:0] count;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      code = 8'($urandom_range(8'h40, 8'h9F));
      plan_byte(code);
      plan_body(fixed_body(code));
    end else if (pick < 45) begin
      code = 8'($urandom_range(8'hA0, 8'hBF));
      sw = size_field_bytes(code);
      body_len = pick_field_value(sw);
      plan_byte(code);
      plan_field(body_len, sw);
      plan_body(body_len);
    end else if (pick < 78) begin
      code = 8'($urandom_range(8'hC0, 8'hFF));
      if ($urandom_range(0, 9) < 3) code = $urandom_range(0, 1) ? TAG_MAP8 : TAG_MAP32;
      sw = size_field_bytes(code);
      cw = count_field_bytes(code);
      body_len = pick_field_value(sw);
      count = pick_field_value(cw);
      // Maps mostly carry key/value pairs; an odd count is the broken case.
      if (code == TAG_MAP8 || code == TAG_MAP32) count[0] = ($urandom_range(0, 4) == 0);
      plan_byte(code);
      plan_field(body_len, sw);
      plan_field(count, cw);
      if (((code == TAG_MAP8 || code == TAG_MAP32) && count[0]) ||
          {29'd0, cw} > body_len) begin
        plan_bytes($urandom_range(0, 5));
        plan_mark();
      end else begin
        plan_body(body_len - {29'd0, cw});
      end
    end else if (pick < 88) begin
      code = 8'($urandom_range(8'hA0, 8'hFF));
      sw = size_field_bytes(code);
      cw = count_field_bytes(code);
      plan_byte(code);
      if (cw == 3'd0 || $urandom_range(0, 1) == 0) begin
        plan_bytes($urandom_range(0, sw - 1));
      end else begin
        plan_field(pick_field_value(sw), sw);
        plan_bytes($urandom_range(0, cw - 1));
      end
      plan_mark();
    end else if (pick < 94) begin
      plan_byte(8'($urandom_range(0, 8'h3F)));
      plan_bytes($urandom_range(0, 6));
      plan_mark();
    end else begin
      if ($urandom_range(0, 1) == 0) plan_byte(8'($urandom_range(0, 255)));
      plan_mark();
    end
  endtask

  initial begin
    int unsigned random_sent;
    random_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    row_given = 1'b0;
    row_res = '0;

    // kind, byte, typed, code, length, count, count width, error
    add_row(KIND_END,  8'h00, 1'b1, 8'h00, 32'd0, 32'd0, 3'd0, ERR_NO_TAG);
    add_row(KIND_BYTE, 8'h40, 1'b1, 8'h40, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'h00, 1'b1, 8'h00, 32'd0, 32'd0, 3'd0, ERR_BAD_TAG);
    add_row(KIND_BYTE, 8'hFF, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_END,  8'hFF, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'h50, 1'b1, 8'h50, 32'd1, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'hFF, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'hA0, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_END,  8'h00, 1'b1, 8'hA0, 32'd0, 32'd0, 3'd0, ERR_SHORT_LEN);
    add_row(KIND_BYTE, TAG_MAP8, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'h03, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'h03, 1'b1, TAG_MAP8, 32'd3, 32'd3, 3'd1, ERR_ODD_MAP);
    add_row(KIND_END,  8'h00, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'hC0, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'h00, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'h00, 1'b1, 8'hC0, 32'd0, 32'd0, 3'd1, ERR_CNT_WIDE);
    add_row(KIND_END,  8'h00, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'hD0, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'h00, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'h00, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'h00, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_BYTE, 8'h05, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_END,  8'h00, 1'b1, 8'hD0, 32'd5, 32'd0, 3'd0, ERR_SHORT_CNT);
    add_row(KIND_BYTE, 8'h9F, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);
    add_row(KIND_END,  8'h00, 1'b0, 8'h00, 32'd0, 32'd0, 3'd0, ERR_OK);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].given, dir_rows[i].res);

    while (random_sent < RANDOM_REQS) begin
      if (random_sent % 150 == 0) begin
        in_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        out_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      calm_tail = (random_sent >= CALM_FROM);
      if (plan_q.size() == 0) plan_value();
      send_req(plan_q.pop_front(), 1'b0, '0);
      random_sent++;
    end
    in_valid <= 1'b0;

    while (header_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d from the table) and %0d header reports.",
             reqs_sent, dir_rows.size(), results_seen);
    $display("Reports by error code 0..6: %0d %0d %0d %0d %0d %0d %0d; failures: %0d",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3], err_seen[4],
             err_seen[5], err_seen[6], fail_count);
    if (fail_count == 0 && header_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ahd_pkg.sv
rtl/ahd_in_stage.sv
rtl/ahd_decode.sv
rtl/ahd_out_stage.sv
rtl/amqp_type_header_decoder_core.sv
rtl/ahd_checker.sv
sim/tb_top.sv
